// ===== rtl/nmea_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_pkg
// Shared types, character codes and helpers for the NMEA RMC/GGA parser.
// ----------------------------------------------------------------------------
package nmea_pkg;

   localparam int TERM_CHARS = 16;
   localparam int TPTR_W     = $clog2(TERM_CHARS);

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_W     = 8'h57;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;
   localparam logic [7:0] CH_HIGH  = 8'h80;

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_RMC   = 2'd1;
   localparam logic [1:0] KIND_GGA   = 2'd2;

   localparam logic [2:0] F_TIME   = 3'd0;
   localparam logic [2:0] F_DATE   = 3'd1;
   localparam logic [2:0] F_LAT    = 3'd2;
   localparam logic [2:0] F_LON    = 3'd3;
   localparam logic [2:0] F_ALT    = 3'd4;
   localparam logic [2:0] F_SPEED  = 3'd5;
   localparam logic [2:0] F_COURSE = 3'd6;
   localparam int NFIELDS = 7;

   // n / 100 == (n * RECIP100) >> 37 for any 32-bit n
   localparam logic [63:0] RECIP100 = 64'd1374389535;
   // n / 6 == (n * RECIP6) >> 24 for n below 2**20
   localparam logic [43:0] RECIP6   = 44'd2796203;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_DEC,
      OP_DEG,
      OP_DATE
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHAR,
      ST_TERM,
      ST_INT,
      ST_DOT,
      ST_FRAC1,
      ST_FRAC2,
      ST_DFRAC,
      ST_DIV,
      ST_REM,
      ST_SCALE,
      ST_RECIP,
      ST_WRITE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic take;
      logic do_char;
      logic do_term;
      logic int_step;
      logic dot_step;
      logic frac1_step;
      logic frac2_step;
      logic dfrac_step;
      logic div_step;
      logic rem_step;
      logic scale_step;
      logic recip_step;
      logic write_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic   delim;
      logic   digit;
      logic   dot;
      op_type op;
      op_type op_next;
   } sts_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [7:0] hex_val(input logic [7:0] a);
      logic [7:0] r;
      if (a >= CH_A && a <= CH_UF) r = a - CH_A + 8'd10;
      else if (a >= CH_LA && a <= CH_LF_HEX) r = a - CH_LA + 8'd10;
      else r = a - CH_ZERO;
      return r;
   endfunction

   // term is a prefix of tag (empty term included); tag ends in a zero byte
   function automatic logic is_prefix(input logic [5:0][7:0] b, input logic [5:0][7:0] tag);
      logic ok;
      logic alive;
      ok    = 1'b0;
      alive = 1'b1;
      for (int j = 0; j < 6; j++) begin
         if (alive) begin
            if (b[j] == 8'd0) begin
               ok    = 1'b1;
               alive = 1'b0;
            end else if (b[j] != tag[j]) begin
               alive = 1'b0;
            end
         end
      end
      return ok;
   endfunction

   // weight of each minutes fraction digit, ten-thousandths
   function automatic logic [13:0] frac_weight(input logic [2:0] idx);
      logic [13:0] w;
      case (idx)
         3'd0: w = 14'd1000;
         3'd1: w = 14'd100;
         3'd2: w = 14'd10;
         3'd3: w = 14'd1;
         default: w = 14'd0;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/nmea_rmc_gga_sentence_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_gga_sentence_parser
// NMEA 0183 RMC/GGA parser, one character in and one status word out.
// ----------------------------------------------------------------------------
//  channel | ports                         | dir | word
//  req     | req_valid/req_ready           | in  | req_rx_char
//  rsp     | rsp_valid/rsp_ready           | out | sentence status and fields
//
//  a plain character runs the char and out states, a delimiter adds the term
//  state if no number is parsed; number terms walk the term buffer one
//  character a cycle (single read port), degrees then four multiply stages
//  the next word is accepted while the previous result waits in rsp
//  reset is synchronous; it clears parser state and the rsp valid
// ----------------------------------------------------------------------------
module nmea_rmc_gga_sentence_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_char,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_sentence_ok,
   output logic [1:0]         rsp_sentence_kind,
   output logic               rsp_ever_good,
   output logic [31:0]        rsp_fix_time,
   output logic [31:0]        rsp_fix_date,
   output logic signed [31:0] rsp_latitude,
   output logic signed [31:0] rsp_longitude,
   output logic signed [31:0] rsp_altitude,
   output logic signed [31:0] rsp_ground_speed,
   output logic signed [31:0] rsp_course
);
   import nmea_pkg::*;

   cmd_type cmd;
   sts_type sts;

   nmea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nmea_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_rx_char       (req_rx_char),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_sentence_ok   (rsp_sentence_ok),
      .rsp_sentence_kind (rsp_sentence_kind),
      .rsp_ever_good     (rsp_ever_good),
      .rsp_fix_time      (rsp_fix_time),
      .rsp_fix_date      (rsp_fix_date),
      .rsp_latitude      (rsp_latitude),
      .rsp_longitude     (rsp_longitude),
      .rsp_altitude      (rsp_altitude),
      .rsp_ground_speed  (rsp_ground_speed),
      .rsp_course        (rsp_course)
   );

   // one word in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a word is in work");

   // a committed sentence implies the sticky flag
   a_ok_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_sentence_ok || rsp_ever_good))
      else $error("sentence ok without ever good");

   // the output word is only loaded while the rsp slot is empty or being taken
   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over an untaken word");

endmodule

// ===== rtl/nmea_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_ctrl
// Sequencer: takes a character, runs the term walk and hands the result out.
// ----------------------------------------------------------------------------
module nmea_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  nmea_pkg::sts_type sts,
   output nmea_pkg::cmd_type cmd
);
   import nmea_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CHAR;
         ST_CHAR:  state_in = sts.delim ? ST_TERM : ST_OUT;
         ST_TERM:  state_in = (sts.op_next == OP_NONE) ? ST_OUT : ST_INT;
         ST_INT: begin
            if (!sts.digit) state_in = (sts.op == OP_DATE) ? ST_WRITE : ST_DOT;
         end
         ST_DOT: begin
            if (sts.dot) state_in = (sts.op == OP_DEC) ? ST_FRAC1 : ST_DFRAC;
            else state_in = (sts.op == OP_DEC) ? ST_WRITE : ST_DIV;
         end
         ST_FRAC1: state_in = sts.digit ? ST_FRAC2 : ST_WRITE;
         ST_FRAC2: state_in = ST_WRITE;
         ST_DFRAC: if (!sts.digit) state_in = ST_DIV;
         ST_DIV:   state_in = ST_REM;
         ST_REM:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_RECIP;
         ST_RECIP: state_in = ST_WRITE;
         ST_WRITE: state_in = ST_OUT;
         ST_OUT:   if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_ready      = (state_ff == ST_IDLE);
      cmd.take       = (state_ff == ST_IDLE) && req_valid;
      cmd.do_char    = (state_ff == ST_CHAR);
      cmd.do_term    = (state_ff == ST_TERM);
      cmd.int_step   = (state_ff == ST_INT);
      cmd.dot_step   = (state_ff == ST_DOT);
      cmd.frac1_step = (state_ff == ST_FRAC1);
      cmd.frac2_step = (state_ff == ST_FRAC2);
      cmd.dfrac_step = (state_ff == ST_DFRAC);
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.rem_step   = (state_ff == ST_REM);
      cmd.scale_step = (state_ff == ST_SCALE);
      cmd.recip_step = (state_ff == ST_RECIP);
      cmd.write_step = (state_ff == ST_WRITE);
      cmd.out_load   = (state_ff == ST_OUT) && slot_free;
      rsp_valid_in   = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/nmea_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_dp
// Parser state, term buffer, number walk, pending and committed fields.
// ----------------------------------------------------------------------------
module nmea_dp (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_rx_char,
   input  nmea_pkg::cmd_type  cmd,
   output nmea_pkg::sts_type  sts,
   output logic               rsp_sentence_ok,
   output logic [1:0]         rsp_sentence_kind,
   output logic               rsp_ever_good,
   output logic [31:0]        rsp_fix_time,
   output logic [31:0]        rsp_fix_date,
   output logic signed [31:0] rsp_latitude,
   output logic signed [31:0] rsp_longitude,
   output logic signed [31:0] rsp_altitude,
   output logic signed [31:0] rsp_ground_speed,
   output logic signed [31:0] rsp_course
);
   import nmea_pkg::*;

   localparam logic [5:0][7:0] RMC_TAG = {8'h00, 8'h43, 8'h4D, 8'h52, 8'h50, 8'h47};
   localparam logic [5:0][7:0] GGA_TAG = {8'h00, 8'h41, 8'h47, 8'h47, 8'h50, 8'h47};

   logic [7:0]        char_ff, char_in;
   logic [7:0]        parity_ff, parity_in;
   logic              inchk_ff, inchk_in;
   logic [7:0]        buf_ff [TERM_CHARS];
   logic [7:0]        buf_in [TERM_CHARS];
   logic [TPTR_W-1:0] tlen_ff, tlen_in;
   logic [3:0]        tidx_ff, tidx_in;
   logic [1:0]        kind_ff, kind_in;
   logic              good_ff, good_in;
   logic              ever_ff, ever_in;
   logic              ok_ff, ok_in;
   logic [31:0]       pend_ff [NFIELDS];
   logic [31:0]       pend_in [NFIELDS];
   logic [31:0]       com_ff [NFIELDS];
   logic [31:0]       com_in [NFIELDS];

   // term walk
   op_type            op_ff, op_in, op_next;
   logic [2:0]        fld_ff, fld_in, fld_next;
   logic [TPTR_W:0]   ptr_ff, ptr_in;
   logic              neg_ff, neg_in;
   logic [31:0]       acc_ff, acc_in;
   logic [6:0]        frac_ff, frac_in;
   logic [13:0]       tenk_ff, tenk_in;
   logic [2:0]        midx_ff, midx_in;
   logic [25:0]       quo_ff, quo_in;
   logic [6:0]        rem_ff, rem_in;
   logic [31:0]       hi_ff, hi_in;
   logic [19:0]       tot_ff, tot_in;
   logic [17:0]       lo_ff, lo_in;

   logic [7:0]        cur;
   logic [3:0]        dig;
   logic              delim;
   logic [5:0][7:0]   head;
   logic [7:0]        b0;
   logic [7:0]        hex_hi;
   logic [7:0]        hex_lo;
   logic [7:0]        chk_sum;
   logic [63:0]       quo_prod;
   logic [43:0]       lo_prod;
   logic [31:0]       dec_val;

   assign cur   = ptr_ff[TPTR_W] ? 8'd0 : buf_ff[ptr_ff[TPTR_W-1:0]];
   assign dig   = 4'(cur - CH_ZERO);
   assign b0    = buf_ff[0];
   assign delim = (char_ff == CH_COMMA) || (char_ff == CH_CR) ||
                  (char_ff == CH_LF) || (char_ff == CH_STAR);
   assign hex_hi  = hex_val(buf_ff[0]);
   assign hex_lo  = hex_val(buf_ff[1]);
   assign chk_sum = {hex_hi[3:0], 4'd0} + hex_lo;

   always_comb begin
      for (int i = 0; i < 6; i++) head[i] = buf_ff[i];
   end

   // what the finished data term asks for
   always_comb begin
      op_next  = OP_NONE;
      fld_next = F_TIME;
      if (!inchk_ff && tidx_ff != 4'd0 && kind_ff != KIND_OTHER && b0 != 8'd0) begin
         if (kind_ff == KIND_RMC) begin
            case (tidx_ff)
               4'd1: begin op_next = OP_DEC;  fld_next = F_TIME;   end
               4'd3: begin op_next = OP_DEG;  fld_next = F_LAT;    end
               4'd5: begin op_next = OP_DEG;  fld_next = F_LON;    end
               4'd7: begin op_next = OP_DEC;  fld_next = F_SPEED;  end
               4'd8: begin op_next = OP_DEC;  fld_next = F_COURSE; end
               4'd9: begin op_next = OP_DATE; fld_next = F_DATE;   end
               default: op_next = OP_NONE;
            endcase
         end else begin
            case (tidx_ff)
               4'd1: begin op_next = OP_DEC; fld_next = F_TIME; end
               4'd2: begin op_next = OP_DEG; fld_next = F_LAT;  end
               4'd4: begin op_next = OP_DEG; fld_next = F_LON;  end
               4'd9: begin op_next = OP_DEC; fld_next = F_ALT;  end
               default: op_next = OP_NONE;
            endcase
         end
      end
   end

   assign quo_prod = {32'd0, acc_ff} * RECIP100;
   assign lo_prod  = {24'd0, tot_ff} * RECIP6;
   assign dec_val  = (acc_ff * 32'd100) + {25'd0, frac_ff};

   always_comb begin
      char_in   = char_ff;
      parity_in = parity_ff;
      inchk_in  = inchk_ff;
      buf_in    = buf_ff;
      tlen_in   = tlen_ff;
      tidx_in   = tidx_ff;
      kind_in   = kind_ff;
      good_in   = good_ff;
      ever_in   = ever_ff;
      ok_in     = ok_ff;
      pend_in   = pend_ff;
      com_in    = com_ff;
      op_in     = op_ff;
      fld_in    = fld_ff;
      ptr_in    = ptr_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      frac_in   = frac_ff;
      tenk_in   = tenk_ff;
      midx_in   = midx_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      hi_in     = hi_ff;
      tot_in    = tot_ff;
      lo_in     = lo_ff;

      if (cmd.take) char_in = req_rx_char;

      if (cmd.do_char) begin
         ok_in = 1'b0;
         if (delim) begin
            if (char_ff == CH_COMMA) parity_in = parity_ff ^ char_ff;
            buf_in[tlen_ff] = 8'd0;
         end else if (char_ff == CH_DOLLAR) begin
            tidx_in   = 4'd0;
            tlen_in   = '0;
            parity_in = 8'd0;
            kind_in   = KIND_OTHER;
            inchk_in  = 1'b0;
            good_in   = 1'b0;
         end else begin
            if (tlen_ff != TPTR_W'(TERM_CHARS - 1)) begin
               buf_in[tlen_ff] = char_ff;
               tlen_in         = tlen_ff + 1'b1;
            end
            if (!inchk_ff) parity_in = parity_ff ^ char_ff;
         end
      end

      if (cmd.do_term) begin
         if (inchk_ff) begin
            if (chk_sum == parity_ff && good_ff) begin
               ever_in = 1'b1;
               ok_in   = 1'b1;
               if (kind_ff == KIND_RMC) begin
                  com_in[F_TIME]   = pend_ff[F_TIME];
                  com_in[F_DATE]   = pend_ff[F_DATE];
                  com_in[F_LAT]    = pend_ff[F_LAT];
                  com_in[F_LON]    = pend_ff[F_LON];
                  com_in[F_SPEED]  = pend_ff[F_SPEED];
                  com_in[F_COURSE] = pend_ff[F_COURSE];
               end else if (kind_ff == KIND_GGA) begin
                  com_in[F_ALT]  = pend_ff[F_ALT];
                  com_in[F_TIME] = pend_ff[F_TIME];
                  com_in[F_LAT]  = pend_ff[F_LAT];
                  com_in[F_LON]  = pend_ff[F_LON];
               end
            end
         end else if (tidx_ff == 4'd0) begin
            if (is_prefix(head, RMC_TAG)) kind_in = KIND_RMC;
            else if (is_prefix(head, GGA_TAG)) kind_in = KIND_GGA;
            else kind_in = KIND_OTHER;
         end else if (kind_ff != KIND_OTHER && b0 != 8'd0) begin
            if (kind_ff == KIND_RMC) begin
               case (tidx_ff)
                  4'd2: good_in = (b0 == CH_A);
                  4'd4: if (b0 == CH_S) pend_in[F_LAT] = 32'd0 - pend_ff[F_LAT];
                  4'd6: if (b0 == CH_W) pend_in[F_LON] = 32'd0 - pend_ff[F_LON];
                  default: ;
               endcase
            end else begin
               case (tidx_ff)
                  4'd3: if (b0 == CH_S) pend_in[F_LAT] = 32'd0 - pend_ff[F_LAT];
                  4'd5: if (b0 == CH_W) pend_in[F_LON] = 32'd0 - pend_ff[F_LON];
                  4'd6: good_in = (b0 > CH_ZERO) && (b0 < CH_HIGH);
                  default: ;
               endcase
            end
         end
         if (tidx_ff != 4'd15) tidx_in = tidx_ff + 4'd1;
         tlen_in  = '0;
         inchk_in = (char_ff == CH_STAR);
         op_in    = op_next;
         fld_in   = fld_next;
         neg_in   = (op_next == OP_DEC) && (b0 == CH_MINUS);
         ptr_in   = ((op_next == OP_DEC) && (b0 == CH_MINUS)) ? (TPTR_W+1)'(1) : '0;
         acc_in   = 32'd0;
         frac_in  = 7'd0;
         tenk_in  = 14'd0;
         midx_in  = 3'd0;
      end

      if (cmd.int_step && is_digit(cur)) begin
         acc_in = (acc_ff * 32'd10) + {28'd0, dig};
         ptr_in = ptr_ff + 1'b1;
      end
      if (cmd.dot_step && cur == CH_DOT) ptr_in = ptr_ff + 1'b1;
      if (cmd.frac1_step && is_digit(cur)) begin
         frac_in = 7'(dig) * 7'd10;
         ptr_in  = ptr_ff + 1'b1;
      end
      if (cmd.frac2_step && is_digit(cur)) frac_in = frac_ff + 7'(dig);
      if (cmd.dfrac_step && is_digit(cur)) begin
         tenk_in = tenk_ff + frac_weight(midx_ff) * 14'(dig);
         if (midx_ff != 3'd4) midx_in = midx_ff + 3'd1;
         ptr_in  = ptr_ff + 1'b1;
      end
      if (cmd.div_step) quo_in = quo_prod[62:37];
      if (cmd.rem_step) begin
         rem_in = 7'(acc_ff - 32'(quo_ff) * 32'd100);
         hi_in  = 32'(quo_ff) * 32'd100000;
      end
      if (cmd.scale_step) tot_in = 20'(rem_ff) * 20'd10000 + 20'(tenk_ff);
      if (cmd.recip_step) lo_in = lo_prod[41:24];
      if (cmd.write_step) begin
         case (op_ff)
            OP_DEC:  pend_in[fld_ff] = neg_ff ? (32'd0 - dec_val) : dec_val;
            OP_DEG:  pend_in[fld_ff] = hi_ff + 32'(lo_ff);
            OP_DATE: pend_in[fld_ff] = acc_ff;
            default: ;
         endcase
      end
   end

   always_comb begin
      sts.delim   = delim;
      sts.digit   = is_digit(cur);
      sts.dot     = (cur == CH_DOT);
      sts.op      = op_ff;
      sts.op_next = op_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 8'd0;
         inchk_ff  <= 1'b0;
         for (int i = 0; i < TERM_CHARS; i++) buf_ff[i] <= 8'd0;
         tlen_ff   <= '0;
         tidx_ff   <= 4'd0;
         kind_ff   <= KIND_OTHER;
         good_ff   <= 1'b0;
         ever_ff   <= 1'b0;
         ok_ff     <= 1'b0;
         op_ff     <= OP_NONE;
         pend_ff[F_TIME]   <= 32'hFFFF_FFFF;
         pend_ff[F_DATE]   <= 32'd0;
         pend_ff[F_LAT]    <= 32'd999999999;
         pend_ff[F_LON]    <= 32'd999999999;
         pend_ff[F_ALT]    <= 32'd999999999;
         pend_ff[F_SPEED]  <= 32'd999999999;
         pend_ff[F_COURSE] <= 32'd999999999;
         for (int i = 0; i < NFIELDS; i++) com_ff[i] <= 32'd0;
      end else begin
         parity_ff <= parity_in;
         inchk_ff  <= inchk_in;
         buf_ff    <= buf_in;
         tlen_ff   <= tlen_in;
         tidx_ff   <= tidx_in;
         kind_ff   <= kind_in;
         good_ff   <= good_in;
         ever_ff   <= ever_in;
         ok_ff     <= ok_in;
         op_ff     <= op_in;
         pend_ff   <= pend_in;
         com_ff    <= com_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      fld_ff  <= fld_in;
      ptr_ff  <= ptr_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
      frac_ff <= frac_in;
      tenk_ff <= tenk_in;
      midx_ff <= midx_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      hi_ff   <= hi_in;
      tot_ff  <= tot_in;
      lo_ff   <= lo_in;
   end

   // result word, held until taken
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_sentence_ok   <= ok_ff;
         rsp_sentence_kind <= kind_ff;
         rsp_ever_good     <= ever_ff;
         rsp_fix_time      <= com_ff[F_TIME];
         rsp_fix_date      <= com_ff[F_DATE];
         rsp_latitude      <= com_ff[F_LAT];
         rsp_longitude     <= com_ff[F_LON];
         rsp_altitude      <= com_ff[F_ALT];
         rsp_ground_speed  <= com_ff[F_SPEED];
         rsp_course        <= com_ff[F_COURSE];
      end
   end

endmodule
